// ===== rtl/ntp_reply_check_and_timebase_assert.svh =====
// Assertion macros for the NTP reply checker.
`ifndef NTP_REPLY_CHECK_AND_TIMEBASE_ASSERT_SVH
`define NTP_REPLY_CHECK_AND_TIMEBASE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTPRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("NTP reply checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NTPRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("NTP reply checker assertion failed");

`endif

// ===== rtl/ntprc_pkg.sv =====
package ntprc_pkg;

  localparam int unsigned CNT_W = 6;
  localparam int unsigned SUB_W = 10;
  localparam int unsigned MS_W  = 42;

  localparam logic [CNT_W-1:0] PACKET_BYTES = 6'd48;
  localparam logic [CNT_W-1:0] TX_FIRST     = 6'd40;
  localparam logic [CNT_W-1:0] TX_LAST      = 6'd43;

  localparam logic [2:0]  SERVER_MODE  = 3'd4;
  localparam logic [7:0]  STRATUM_MAX  = 8'd15;
  localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
  localparam logic [31:0] WIN_LO_RST   = 32'd3155673600;
  localparam logic [31:0] WIN_HI_RST   = 32'd4260211200;
  localparam logic [SUB_W-1:0] MS_PER_SEC = 10'd1000;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_REQUEST = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2
  } ev_e;

  typedef enum logic [0:0] {
    CFG_MIN_SEC = 1'b0,
    CFG_MAX_SEC = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/ntprc_if.sv =====
interface ntprc_in_if import ntprc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] reply_byte;
  logic       last_byte;

  modport source (output valid, opcode, reply_byte, last_byte, input ready);
  modport sink (input valid, opcode, reply_byte, last_byte, output ready);
endinterface

interface ntprc_res_if import ntprc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [1:0]      event_res;
  logic            time_valid;
  logic            fresh_reply;
  logic [31:0]     now_seconds;
  logic [MS_W-1:0] now_milliseconds;

  modport source (output valid, event_res, time_valid, fresh_reply, now_seconds,
                  now_milliseconds, input ready);
  modport sink (input valid, event_res, time_valid, fresh_reply, now_seconds,
                now_milliseconds, output ready);
endinterface

interface ntprc_cfg_if import ntprc_pkg::*;;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ntp_reply_check_and_timebase.sv =====
// NTP reply checker and Unix timebase.
// The in_i channel carries one item per reply byte, millisecond tick or
// request-sent event, selected by opcode. The last byte of a reply is marked
// by last_byte; on it the reply is judged on length, mode, stratum and the
// transmit seconds window, and an accepted reply loads the Unix seconds.
// The res_o channel returns one item per input item: the event, the valid
// and fresh flags, and the current seconds and milliseconds (zero until sync).
// The cfg_i channel writes the window bounds; it is always ready and should
// only be written while the block is idle.
// One item is accepted every cycle while res_o takes its results. The state
// update sits between the input handshake and a result register; the
// milliseconds product is formed in a second register that drives res_o.
// Reset clears the reply state and both flags and loads the window bounds
// with the years 2000 and 2035. When res_o is stalled, the two stages fill
// and in_i drops ready only when both hold an item.
`include "ntp_reply_check_and_timebase_assert.svh"

module ntp_reply_check_and_timebase import ntprc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ntprc_in_if.sink     in_i,
  ntprc_res_if.source  res_o,
  ntprc_cfg_if.sink    cfg_i
);

  logic [31:0] win_lo_q, win_hi_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mode_q, mode_d;
  logic             strat_q, strat_d;
  logic [31:0]      tx_q, tx_d;
  logic             valid_q, valid_d;
  logic             fresh_q, fresh_d;
  logic [31:0]      sec_q, sec_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  ev_e              ev_d;
  logic             reply_ok;

  logic             in_acc;
  logic             adv2;

  logic             r1_v_q;
  ev_e              r1_ev_q;
  logic             r1_valid_q, r1_fresh_q;
  logic [31:0]      r1_sec_q;
  logic [SUB_W-1:0] r1_sub_q;

  logic             res_v_q;
  ev_e              res_ev_q;
  logic             res_valid_q, res_fresh_q;
  logic [31:0]      res_sec_q;
  logic [MS_W-1:0]  res_ms_q;
  logic [MS_W-1:0]  ms_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= WIN_LO_RST;
      win_hi_q <= WIN_HI_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_MIN_SEC: win_lo_q <= cfg_i.data;
        CFG_MAX_SEC: win_hi_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign adv2       = !res_v_q || res_o.ready;
  assign in_i.ready = !r1_v_q || adv2;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    strat_d  = strat_q;
    tx_d     = tx_q;
    valid_d  = valid_q;
    fresh_d  = fresh_q;
    sec_d    = sec_q;
    sub_d    = sub_q;
    ev_d     = EV_NONE;
    reply_ok = 1'b0;
    unique case (op_e'(in_i.opcode))
      OP_BYTE: begin
        if (cnt_q < PACKET_BYTES) begin
          if (cnt_q == '0) begin
            mode_d = in_i.reply_byte[2:0] == SERVER_MODE;
          end else if (cnt_q == CNT_W'(1)) begin
            strat_d = (in_i.reply_byte != '0) && (in_i.reply_byte <= STRATUM_MAX);
          end
          if (cnt_q >= TX_FIRST && cnt_q <= TX_LAST) begin
            tx_d = {tx_q[23:0], in_i.reply_byte};
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (in_i.last_byte) begin
          reply_ok = (cnt_d >= PACKET_BYTES) && mode_d && strat_d
                     && (tx_d >= win_lo_q) && (tx_d <= win_hi_q);
          if (reply_ok) begin
            sec_d   = tx_d - EPOCH_OFFSET;
            sub_d   = '0;
            valid_d = 1'b1;
            fresh_d = 1'b1;
            ev_d    = EV_ACCEPT;
          end else begin
            ev_d = EV_REJECT;
          end
          cnt_d   = '0;
          mode_d  = 1'b0;
          strat_d = 1'b0;
          tx_d    = '0;
        end
      end
      OP_TICK: begin
        if (valid_q) begin
          if (sub_q == MS_PER_SEC - SUB_W'(1)) begin
            sub_d = '0;
            sec_d = sec_q + 32'd1;
          end else begin
            sub_d = sub_q + SUB_W'(1);
          end
        end
      end
      OP_REQUEST: fresh_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      mode_q  <= 1'b0;
      strat_q <= 1'b0;
      tx_q    <= '0;
      valid_q <= 1'b0;
      fresh_q <= 1'b0;
      sec_q   <= '0;
      sub_q   <= '0;
    end else if (in_acc) begin
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      strat_q <= strat_d;
      tx_q    <= tx_d;
      valid_q <= valid_d;
      fresh_q <= fresh_d;
      sec_q   <= sec_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else if (in_acc) begin
      r1_v_q <= 1'b1;
    end else if (adv2) begin
      r1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r1_ev_q    <= ev_d;
      r1_valid_q <= valid_d;
      r1_fresh_q <= fresh_d;
      r1_sec_q   <= valid_d ? sec_d : '0;
      r1_sub_q   <= valid_d ? sub_d : '0;
    end
  end

  // Seconds times 1000 as (s << 10) - (s << 4) - (s << 3).
  assign ms_d = (MS_W'(r1_sec_q) << 10) - (MS_W'(r1_sec_q) << 4)
                - (MS_W'(r1_sec_q) << 3) + MS_W'(r1_sub_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (adv2) begin
      res_v_q <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && r1_v_q) begin
      res_ev_q    <= r1_ev_q;
      res_valid_q <= r1_valid_q;
      res_fresh_q <= r1_fresh_q;
      res_sec_q   <= r1_sec_q;
      res_ms_q    <= ms_d;
    end
  end

  assign res_o.valid            = res_v_q;
  assign res_o.event_res        = res_ev_q;
  assign res_o.time_valid       = res_valid_q;
  assign res_o.fresh_reply      = res_fresh_q;
  assign res_o.now_seconds      = res_sec_q;
  assign res_o.now_milliseconds = res_ms_q;

  `NTPRC_ASSERT_NOW(a_sub_range, 1'b1, sub_q < MS_PER_SEC)
  `NTPRC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= PACKET_BYTES)
  `NTPRC_ASSERT_NOW(a_fresh_needs_valid, fresh_q, valid_q)
  `NTPRC_ASSERT_NOW(a_clock_idle_unsynced, !valid_q, (sec_q == '0) && (sub_q == '0))
  `NTPRC_ASSERT_NEXT(a_reply_cleared, in_acc && (in_i.opcode == OP_BYTE) && in_i.last_byte,
                     (cnt_q == '0) && (tx_q == '0))

endmodule
